/* design/efr_pkg.sv */
package efr_pkg;

    localparam int BUFFER_DEPTH_DEF = 64;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [1:0] REG_START_BYTE  = 2'd0;
    localparam logic [1:0] REG_END_BYTE    = 2'd1;
    localparam logic [1:0] REG_ESCAPE_BYTE = 2'd2;
    localparam logic [1:0] REG_QUIET_TICKS = 2'd3;

    localparam logic [7:0] START_BYTE_RST  = 8'd2;
    localparam logic [7:0] END_BYTE_RST    = 8'd3;
    localparam logic [7:0] ESCAPE_BYTE_RST = 8'd16;
    localparam logic [7:0] QUIET_TICKS_RST = 8'd10;

    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_NORMAL,
        MODE_ESCAPED,
        MODE_CLOSED
    } rx_mode_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_FETCH,
        SEQ_SHOW
    } seq_state_t;

endpackage

/* design/efr_ram.sv */
module efr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/escaped_frame_receiver.sv */
// a byte or a tick that delivers nothing is accepted while no delivery is running
// a delivering tick reads stored payload bytes one at a time from the frame ram,
// each fetched then shown until m_tready, up to buffer depth minus two bytes
// s_tready is low for the whole delivery; throughput is one transaction per cycle otherwise
// reset: asynchronous active low, clears mode, quiet counter, byte count, frame count
// and loads the default start, end, escape and quiet values; the frame ram is not cleared
module escaped_frame_receiver #(
    parameter int BUFFER_DEPTH = efr_pkg::BUFFER_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // rx_byte
    input  logic                            s_tuser,   // req_type
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [15:0]                     m_tdata,   // payload_byte, frame_number
    output logic                            m_tlast,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [efr_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [efr_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [efr_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    import efr_pkg::*;

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int CW = $clog2(BUFFER_DEPTH + 1);

    logic [7:0]  start_byte_reg;
    logic [7:0]  end_byte_reg;
    logic [7:0]  escape_byte_reg;
    logic [7:0]  quiet_ticks_reg;

    seq_state_t  state_reg, state_next;
    rx_mode_t    mode_reg, mode_next;
    logic [7:0]  quiet_reg, quiet_next;
    logic [CW-1:0] count_reg, count_next;
    logic [7:0]  frames_reg, frames_next;
    logic [AW-1:0] idx_reg, idx_next;

    logic          ram_we;
    logic          ram_re;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_rdata;
    logic          store_en;
    logic          last;
    logic          cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg  <= START_BYTE_RST;
            end_byte_reg    <= END_BYTE_RST;
            escape_byte_reg <= ESCAPE_BYTE_RST;
            quiet_ticks_reg <= QUIET_TICKS_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_START_BYTE:  start_byte_reg  <= pwdata[7:0];
                REG_END_BYTE:    end_byte_reg    <= pwdata[7:0];
                REG_ESCAPE_BYTE: escape_byte_reg <= pwdata[7:0];
                REG_QUIET_TICKS: quiet_ticks_reg <= pwdata[7:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_START_BYTE:  prdata = {24'd0, start_byte_reg};
            REG_END_BYTE:    prdata = {24'd0, end_byte_reg};
            REG_ESCAPE_BYTE: prdata = {24'd0, escape_byte_reg};
            REG_QUIET_TICKS: prdata = {24'd0, quiet_ticks_reg};
            default:         prdata = '0;
        endcase
    end

    efr_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH)
    ) u_frame_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (s_tdata),
        .re    (ram_re),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= SEQ_IDLE;
            mode_reg   <= MODE_IDLE;
            quiet_reg  <= '0;
            count_reg  <= '0;
            frames_reg <= '0;
            idx_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            mode_reg   <= mode_next;
            quiet_reg  <= quiet_next;
            count_reg  <= count_next;
            frames_reg <= frames_next;
            idx_reg    <= idx_next;
        end
    end

    assign last = (CW'(idx_reg) == count_reg - CW'(2));

    always_comb
    begin
        state_next  = state_reg;
        mode_next   = mode_reg;
        quiet_next  = quiet_reg;
        count_next  = count_reg;
        frames_next = frames_reg;
        idx_next    = idx_reg;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_waddr   = count_reg[AW-1:0];
        store_en    = 1'b0;
        s_tready    = 1'b0;
        m_tvalid    = 1'b0;

        case (state_reg)
            SEQ_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (s_tuser == REQ_BYTE)
                    begin
                        if (quiet_reg == 8'd0 && s_tdata == start_byte_reg)
                        begin
                            // new frame, store restarts with the start byte
                            ram_we     = 1'b1;
                            ram_waddr  = '0;
                            count_next = CW'(1);
                            quiet_next = quiet_ticks_reg;
                            mode_next  = MODE_NORMAL;
                        end
                        else if (mode_reg == MODE_NORMAL)
                        begin
                            quiet_next = quiet_ticks_reg;
                            if (s_tdata == escape_byte_reg)
                            begin
                                mode_next = MODE_ESCAPED;
                            end
                            else if (s_tdata == end_byte_reg)
                            begin
                                store_en  = 1'b1;
                                mode_next = MODE_CLOSED;
                            end
                            else
                            begin
                                store_en = 1'b1;
                            end
                        end
                        else if (mode_reg == MODE_ESCAPED)
                        begin
                            quiet_next = quiet_ticks_reg;
                            store_en   = 1'b1;
                            mode_next  = MODE_NORMAL;
                        end

                        // bytes past the buffer end are dropped
                        if (store_en && count_reg < CW'(BUFFER_DEPTH))
                        begin
                            ram_we     = 1'b1;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    else
                    begin
                        if (quiet_reg != 8'd0)
                        begin
                            quiet_next = quiet_reg - 8'd1;
                        end
                        else if (mode_reg == MODE_CLOSED)
                        begin
                            mode_next = MODE_IDLE;
                            if (count_reg > CW'(2))
                            begin
                                frames_next = frames_reg + 8'd1;
                                idx_next    = AW'(1);
                                state_next  = SEQ_FETCH;
                            end
                            else
                            begin
                                count_next = '0;
                            end
                        end
                    end
                end
            end

            SEQ_FETCH:
            begin
                ram_re     = 1'b1;
                state_next = SEQ_SHOW;
            end

            SEQ_SHOW:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                begin
                    if (last)
                    begin
                        count_next = '0;
                        state_next = SEQ_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = SEQ_FETCH;
                    end
                end
            end

            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    assign m_tdata = {frames_reg, ram_rdata};
    assign m_tlast = last;

endmodule
